FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SGOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SGOG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SGOG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sgog_pkg.sv
`timescale 1ns / 1ps

package sgog_pkg;

  localparam int unsigned MaxDims    = 4;
  localparam int unsigned SizeBits   = 16;
  localparam int unsigned StrideBits = 32;
  localparam int unsigned OfsBits    = 48;
  // Accumulator holds the sum of up to five offset terms without wrapping.
  localparam int unsigned AccBits    = OfsBits + 3;

  // Configuration register indexes.
  localparam logic [2:0] CfgNumDims    = 3'd0;
  localparam logic [2:0] CfgSelectDim  = 3'd1;
  localparam logic [2:0] CfgDimSizes   = 3'd2;
  localparam logic [2:0] CfgSrcStrLow  = 3'd3;
  localparam logic [2:0] CfgSrcStrHigh = 3'd4;
  localparam logic [2:0] CfgDstStrLow  = 3'd5;
  localparam logic [2:0] CfgDstStrHigh = 3'd6;

  // Work carried from cell to cell along the chain.
  typedef struct packed {
    logic [SizeBits-1:0] rem;    // partial remainder, later the coordinate
    logic [OfsBits-1:0]  work;   // dividend bits in, quotient bits out
    logic [AccBits-1:0]  acc_s;  // source offset so far
    logic [AccBits-1:0]  acc_d;  // destination offset so far
  } item_t;

endpackage

FILE: src/strided_gather_offset_generator_top.sv
`timescale 1ns / 1ps

// Strided gather offset generator. Takes one request per clock while the
// chain is not held and returns one source/destination offset pair per
// request, in order. Each request passes a row of 152 registers. There
// is one entry register. For each of dimensions 3, 2 and 1 the copy number
// passes 48 one-bit division cells and one multiply-add cell. Dimension 0 then
// takes three more stages for its split 48x32 product. Last comes the output
// register. Dimensions not in use or selected divide by one and add nothing.
// A two-entry output buffer lets the chain keep accepting while a result
// waits. When both entries are full, the chain holds.
`include "assert_macros.svh"

module strided_gather_offset_generator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration writes.
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i,
  // Requests in.
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [79:0]  s_tdata_i,   // list_position[15:0], slice_number[31:16],
                                    // copy_number[79:32]
  // Results out.
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [103:0] m_tdata_o    // source_offset[47:0], dest_offset[95:48],
                                    // offset_overflow[96], zero[103:97]
);

  localparam int unsigned DivSteps  = sgog_pkg::OfsBits;
  localparam int unsigned DimStages = DivSteps + 1;
  localparam int unsigned NumInner  = sgog_pkg::MaxDims - 1;
  localparam int unsigned ChainLen  = NumInner * DimStages;

  // Configuration registers.
  logic [2:0]  num_dims_q;
  logic [1:0]  select_dim_q;
  logic [63:0] dim_sizes_q, src_lo_q, src_hi_q, dst_lo_q, dst_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q   <= 3'd1;
      select_dim_q <= 2'd0;
      dim_sizes_q  <= 64'h0001_0001_0001_0001;
      src_lo_q     <= '0;
      src_hi_q     <= '0;
      dst_lo_q     <= '0;
      dst_hi_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sgog_pkg::CfgNumDims:    num_dims_q   <= cfg_data_i[2:0];
        sgog_pkg::CfgSelectDim:  select_dim_q <= cfg_data_i[1:0];
        sgog_pkg::CfgDimSizes:   dim_sizes_q  <= cfg_data_i;
        sgog_pkg::CfgSrcStrLow:  src_lo_q     <= cfg_data_i;
        sgog_pkg::CfgSrcStrHigh: src_hi_q     <= cfg_data_i;
        sgog_pkg::CfgDstStrLow:  dst_lo_q     <= cfg_data_i;
        sgog_pkg::CfgDstStrHigh: dst_hi_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Decoded configuration: strides per dimension and effective divisors.
  logic [sgog_pkg::StrideBits-1:0] src_str [sgog_pkg::MaxDims];
  logic [sgog_pkg::StrideBits-1:0] dst_str [sgog_pkg::MaxDims];
  logic [sgog_pkg::SizeBits-1:0]   div_sz  [sgog_pkg::MaxDims];
  logic [2:0]                      nd_eff;
  logic [sgog_pkg::StrideBits-1:0] src_sel, dst_sel, src_d0, dst_d0;

  always_comb begin
    if (num_dims_q == 3'd0) begin
      nd_eff = 3'd1;
    end else if (num_dims_q > 3'(sgog_pkg::MaxDims)) begin
      nd_eff = 3'(sgog_pkg::MaxDims);
    end else begin
      nd_eff = num_dims_q;
    end
    for (int d = 0; d < sgog_pkg::MaxDims; d++) begin
      src_str[d] = (d < 2) ? src_lo_q[(d & 1)*32 +: 32] : src_hi_q[(d & 1)*32 +: 32];
      dst_str[d] = (d < 2) ? dst_lo_q[(d & 1)*32 +: 32] : dst_hi_q[(d & 1)*32 +: 32];
      // A zero size counts as one; skipped dimensions divide by one.
      if ((dim_sizes_q[d*16 +: 16] == '0) || (3'(d) >= nd_eff) ||
          (2'(d) == select_dim_q)) begin
        div_sz[d] = 16'd1;
      end else begin
        div_sz[d] = dim_sizes_q[d*16 +: 16];
      end
    end
    src_sel = src_str[select_dim_q];
    dst_sel = dst_str[select_dim_q];
    // Dimension 0 takes the remaining quotient unless it is selected.
    src_d0  = (select_dim_q != 2'd0) ? src_str[0] : '0;
    dst_d0  = (select_dim_q != 2'd0) ? dst_str[0] : '0;
  end

  // Chain enable: everything moves while the spare output entry is empty.
  logic en;
  logic spare_v_q;
  assign en         = !spare_v_q;
  assign s_tready_o = en;

  // Entry stage: start offsets from the selected dimension.
  sgog_pkg::item_t chain [ChainLen+1];
  logic            vld   [ChainLen+1];
  logic            v0_q;
  sgog_pkg::item_t it0_q;
  logic [sgog_pkg::OfsBits-1:0] start_s, start_d;

  assign start_s = sgog_pkg::OfsBits'(s_tdata_i[31:16]) * sgog_pkg::OfsBits'(src_sel);
  assign start_d = sgog_pkg::OfsBits'(s_tdata_i[15:0]) * sgog_pkg::OfsBits'(dst_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it0_q.rem   <= '0;
      it0_q.work  <= s_tdata_i[79:32];
      it0_q.acc_s <= sgog_pkg::AccBits'(start_s);
      it0_q.acc_d <= sgog_pkg::AccBits'(start_d);
    end
  end

  assign chain[0] = it0_q;
  assign vld[0]   = v0_q;

  // Inner dimensions from the highest down to dimension 1.
  for (genvar k = 0; k < NumInner; k++) begin : g_dim
    for (genvar i = 0; i < DivSteps; i++) begin : g_step
      sgog_div_cell u_div (
        .clk_i     (clk_i),
        .rst_ni    (rst_ni),
        .en_i      (en),
        .divisor_i (div_sz[NumInner-k]),
        .valid_i   (vld[k*DimStages+i]),
        .item_i    (chain[k*DimStages+i]),
        .valid_o   (vld[k*DimStages+i+1]),
        .item_o    (chain[k*DimStages+i+1])
      );
    end
    sgog_term_cell u_term (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .src_stride_i (src_str[NumInner-k]),
      .dst_stride_i (dst_str[NumInner-k]),
      .valid_i      (vld[k*DimStages+DivSteps]),
      .item_i       (chain[k*DimStages+DivSteps]),
      .valid_o      (vld[(k+1)*DimStages]),
      .item_o       (chain[(k+1)*DimStages])
    );
  end

  // Dimension 0, stage A: quotient times stride as two 24-bit halves.
  localparam int unsigned Half = sgog_pkg::OfsBits / 2;
  localparam int unsigned PpBits = Half + sgog_pkg::StrideBits;
  localparam int unsigned FullBits = sgog_pkg::OfsBits + sgog_pkg::StrideBits;

  logic                        a_v_q;
  logic [sgog_pkg::AccBits-1:0] a_acc_s_q, a_acc_d_q;
  logic [PpBits-1:0]           a_lo_s_q, a_hi_s_q, a_lo_d_q, a_hi_d_q;
  sgog_pkg::item_t             a_in;

  assign a_in = chain[ChainLen];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= vld[ChainLen];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_acc_s_q <= a_in.acc_s;
      a_acc_d_q <= a_in.acc_d;
      a_lo_s_q  <= PpBits'(a_in.work[Half-1:0]) * PpBits'(src_d0);
      a_hi_s_q  <= PpBits'(a_in.work[sgog_pkg::OfsBits-1:Half]) * PpBits'(src_d0);
      a_lo_d_q  <= PpBits'(a_in.work[Half-1:0]) * PpBits'(dst_d0);
      a_hi_d_q  <= PpBits'(a_in.work[sgog_pkg::OfsBits-1:Half]) * PpBits'(dst_d0);
    end
  end

  // Stage B: combine the halves and flag a product beyond 48 bits.
  logic                         b_v_q, b_movf_q;
  logic [sgog_pkg::AccBits-1:0] b_acc_s_q, b_acc_d_q;
  logic [sgog_pkg::OfsBits-1:0] b_p_s_q, b_p_d_q;
  logic [FullBits-1:0]          full_s, full_d;

  assign full_s = FullBits'(a_lo_s_q) + (FullBits'(a_hi_s_q) << Half);
  assign full_d = FullBits'(a_lo_d_q) + (FullBits'(a_hi_d_q) << Half);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_acc_s_q <= a_acc_s_q;
      b_acc_d_q <= a_acc_d_q;
      b_p_s_q   <= full_s[sgog_pkg::OfsBits-1:0];
      b_p_d_q   <= full_d[sgog_pkg::OfsBits-1:0];
      b_movf_q  <= (full_s[FullBits-1:sgog_pkg::OfsBits] != '0) ||
                   (full_d[FullBits-1:sgog_pkg::OfsBits] != '0);
    end
  end

  // Stage C: final sums; any carry past 48 bits raises the overflow flag.
  logic                         fin_v_q;
  logic [103:0]                 fin_q;
  logic [sgog_pkg::AccBits-1:0] sum_s, sum_d;
  logic                         ovf;

  assign sum_s = b_acc_s_q + sgog_pkg::AccBits'(b_p_s_q);
  assign sum_d = b_acc_d_q + sgog_pkg::AccBits'(b_p_d_q);
  assign ovf   = b_movf_q || (sum_s[sgog_pkg::AccBits-1:sgog_pkg::OfsBits] != '0) ||
                 (sum_d[sgog_pkg::AccBits-1:sgog_pkg::OfsBits] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_v_q <= 1'b0;
    end else if (en) begin
      fin_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_q <= {7'd0, ovf, sum_d[sgog_pkg::OfsBits-1:0], sum_s[sgog_pkg::OfsBits-1:0]};
    end
  end

  // Output register with a spare entry behind it.
  logic         out_v_q;
  logic [103:0] out_q, spare_q;
  logic         out_free, push;

  assign out_free = !out_v_q || m_tready_i;
  assign push     = en && fin_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (out_free) begin
      if (spare_v_q) begin
        out_v_q   <= 1'b1;
        spare_v_q <= 1'b0;
      end else begin
        out_v_q <= push;
      end
    end else if (push) begin
      spare_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= spare_v_q ? spare_q : fin_q;
    end else if (push) begin
      spare_q <= fin_q;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;

  // Checks on the output buffer and the chain.
  `SGOG_ASSERT_IMP(a_spare_behind_out, spare_v_q, out_v_q,
                   "spare entry full while output register empty")
  `SGOG_ASSERT_NXT(a_stall_fills_spare, out_v_q && !m_tready_i && push, spare_v_q,
                   "stalled result not kept in spare entry")
  `SGOG_ASSERT_IMP(a_chain_rem_clear, vld[ChainLen], chain[ChainLen].rem == '0,
                   "coordinate left over at end of division chain")

endmodule

FILE: src/sgog_div_cell.sv
`timescale 1ns / 1ps

// One restoring division step: shifts in the next dividend bit, subtracts
// the divisor when it fits and shifts the quotient bit into the work word.
module sgog_div_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [sgog_pkg::SizeBits-1:0]  divisor_i,
  input  logic                           valid_i,
  input  sgog_pkg::item_t                item_i,
  output logic                           valid_o,
  output sgog_pkg::item_t                item_o
);

  logic                          v_q;
  sgog_pkg::item_t               item_q, item_d;
  logic [sgog_pkg::SizeBits:0]   trial;
  logic [sgog_pkg::SizeBits:0]   diff;
  logic                          fits;

  // Trial subtraction of the divisor from the shifted remainder.
  always_comb begin
    trial  = {item_i.rem, item_i.work[sgog_pkg::OfsBits-1]};
    diff   = trial - {1'b0, divisor_i};
    fits   = (trial >= {1'b0, divisor_i});
    item_d = item_i;
    item_d.rem  = fits ? diff[sgog_pkg::SizeBits-1:0] : trial[sgog_pkg::SizeBits-1:0];
    item_d.work = {item_i.work[sgog_pkg::OfsBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = item_q;

endmodule

FILE: src/sgog_term_cell.sv
`timescale 1ns / 1ps

// Adds the coordinate found by the division cells, times its strides, to
// both offsets and clears the remainder for the next dimension.
module sgog_term_cell (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic [sgog_pkg::StrideBits-1:0] src_stride_i,
  input  logic [sgog_pkg::StrideBits-1:0] dst_stride_i,
  input  logic                            valid_i,
  input  sgog_pkg::item_t                 item_i,
  output logic                            valid_o,
  output sgog_pkg::item_t                 item_o
);

  logic            v_q;
  sgog_pkg::item_t item_q, item_d;
  logic [sgog_pkg::OfsBits-1:0] prod_s, prod_d;

  // A 16-bit coordinate times a 32-bit stride always fits in 48 bits.
  always_comb begin
    prod_s = sgog_pkg::OfsBits'(item_i.rem) * sgog_pkg::OfsBits'(src_stride_i);
    prod_d = sgog_pkg::OfsBits'(item_i.rem) * sgog_pkg::OfsBits'(dst_stride_i);
    item_d       = item_i;
    item_d.rem   = '0;
    item_d.acc_s = item_i.acc_s + sgog_pkg::AccBits'(prod_s);
    item_d.acc_d = item_i.acc_d + sgog_pkg::AccBits'(prod_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = v_q;
  assign item_o  = item_q;

endmodule

FILE: test/strided_gather_offset_generator_top_tb.sv
`timescale 1ns / 1ps

module strided_gather_offset_generator_top_tb;

  // Writes to this index must be ignored by the block.
  localparam logic [2:0] CfgUnused = 3'd7;

  // One expected offset pair with its overflow flag.
  typedef struct packed {
    logic        ovf;
    logic [47:0] dst;
    logic [47:0] src;
  } offsets_t;

  // Keeps the expected offset pairs in order and compares results against them.
  class offset_scoreboard;
    offsets_t pending_q[$];
    int       mismatches;

    function void note_request(offsets_t exp_ofs);
      pending_q.push_back(exp_ofs);
    endfunction

    function void check_result(logic [103:0] got);
      offsets_t exp_ofs;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_ofs = pending_q.pop_front();
      if (got[47:0] !== exp_ofs.src || got[95:48] !== exp_ofs.dst ||
          got[96] !== exp_ofs.ovf || got[103:97] !== 7'd0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp src %h dst %h ovf %b, got src %h dst %h ovf %b pad %h",
                   exp_ofs.src, exp_ofs.dst, exp_ofs.ovf,
                   got[47:0], got[95:48], got[96], got[103:97]);
      end
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [63:0]  cfg_data_i;
  logic         s_tvalid_i;
  logic         s_tready_o;
  logic [79:0]  s_tdata_i;
  logic         m_tvalid_o;
  logic         m_tready_i;
  logic [103:0] m_tdata_o;

  strided_gather_offset_generator_top dut (.*);

  // Shadow copy of the configuration registers.
  logic [2:0]  num_dims_r;
  logic [1:0]  select_dim_r;
  logic [63:0] sizes_r;
  logic [63:0] src_str_lo_r, src_str_hi_r, dst_str_lo_r, dst_str_hi_r;

  offset_scoreboard sb;
  bit quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("strided_gather_offset_generator_top_tb: FAIL");
    $finish;
  end

  function automatic logic [31:0] stride_at(logic [63:0] lo, logic [63:0] hi, int d);
    logic [63:0] w;
    w = (d >= 2) ? hi : lo;
    return (d % 2) ? w[63:32] : w[31:0];
  endfunction

  // Adds a*b to acc modulo 2^48 and flags any term or sum that does not fit.
  function automatic logic [47:0] mac48(logic [47:0] acc, logic [47:0] a, logic [31:0] b,
                                        inout logic ovf);
    logic [79:0] prod;
    logic [48:0] sum;
    prod = a * b;
    if (prod[79:48] != 0) ovf = 1'b1;
    sum = acc + prod[47:0];
    if (sum[48]) ovf = 1'b1;
    return sum[47:0];
  endfunction

  function automatic offsets_t gather_offsets(logic [15:0] pos, logic [15:0] slice,
                                              logic [47:0] copy);
    offsets_t r;
    int nd, sel;
    logic [47:0] rest, coord;
    logic [15:0] sz;
    r.ovf = 1'b0;
    nd = num_dims_r;
    sel = select_dim_r;
    if (nd == 0) nd = 1;
    if (nd > sgog_pkg::MaxDims) nd = sgog_pkg::MaxDims;
    rest = copy;
    r.src = mac48(48'd0, 48'(slice), stride_at(src_str_lo_r, src_str_hi_r, sel), r.ovf);
    r.dst = mac48(48'd0, 48'(pos), stride_at(dst_str_lo_r, dst_str_hi_r, sel), r.ovf);
    // Split the copy number from the innermost dimension outward.
    for (int i = nd - 1; i > 0; i--) begin
      if (i != sel) begin
        sz = sizes_r[i*16 +: 16];
        if (sz == 0) sz = 16'd1;
        coord = rest % sz;
        r.src = mac48(r.src, coord, stride_at(src_str_lo_r, src_str_hi_r, i), r.ovf);
        r.dst = mac48(r.dst, coord, stride_at(dst_str_lo_r, dst_str_hi_r, i), r.ovf);
        rest = rest / sz;
      end
    end
    if (sel != 0) begin
      r.src = mac48(r.src, rest, stride_at(src_str_lo_r, src_str_hi_r, 0), r.ovf);
      r.dst = mac48(r.dst, rest, stride_at(dst_str_lo_r, dst_str_hi_r, 0), r.ovf);
    end
    return r;
  endfunction

  // One register write; valid drops for a cycle before the next write.
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      sgog_pkg::CfgNumDims:    num_dims_r   = val[2:0];
      sgog_pkg::CfgSelectDim:  select_dim_r = val[1:0];
      sgog_pkg::CfgDimSizes:   sizes_r      = val;
      sgog_pkg::CfgSrcStrLow:  src_str_lo_r = val;
      sgog_pkg::CfgSrcStrHigh: src_str_hi_r = val;
      sgog_pkg::CfgDstStrLow:  dst_str_lo_r = val;
      sgog_pkg::CfgDstStrHigh: dst_str_hi_r = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [2:0] nd, logic [1:0] sel, logic [63:0] sizes,
                           logic [63:0] sl, logic [63:0] sh, logic [63:0] dl,
                           logic [63:0] dh);
    write_reg(sgog_pkg::CfgNumDims, {61'd0, nd});
    write_reg(sgog_pkg::CfgSelectDim, {62'd0, sel});
    write_reg(sgog_pkg::CfgDimSizes, sizes);
    write_reg(sgog_pkg::CfgSrcStrLow, sl);
    write_reg(sgog_pkg::CfgSrcStrHigh, sh);
    write_reg(sgog_pkg::CfgDstStrLow, dl);
    write_reg(sgog_pkg::CfgDstStrHigh, dh);
  endtask

  // Leaves tvalid high after the handshake so back-to-back requests need no toggle.
  task automatic send_request(logic [15:0] pos, logic [15:0] slice, logic [47:0] copy);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {copy, slice, pos};
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_request(gather_offsets(pos, slice, copy));
  endtask

  // Drains the pipeline so the configuration can change.
  task automatic settle();
    s_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_sizes();
    logic [63:0] v;
    for (int d = 0; d < 4; d++)
      case ($urandom_range(0, 9))
        0:       v[d*16 +: 16] = 16'd0;
        1:       v[d*16 +: 16] = 16'hFFFF;
        2:       v[d*16 +: 16] = 16'($urandom);
        default: v[d*16 +: 16] = 16'($urandom_range(1, 9));
      endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_stride();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFF_FFFF;
      1:       return $urandom;
      2:       return 32'd0;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  function automatic logic [47:0] rand_copy();
    case ($urandom_range(0, 5))
      0:       return 48'({$urandom, $urandom});
      1:       return 48'($urandom_range(0, 65535));
      default: return 48'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [15:0] rand_index();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
  endfunction

  task automatic random_burst(int count);
    repeat (count) send_request(rand_index(), rand_index(), rand_copy());
  endtask

  // Result side: ready drops for a random number of cycles after each result.
  initial begin
    int hold;
    hold = 0;
    m_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_tvalid_o && m_tready_i) begin
        sb.check_result(m_tdata_o);
        hold = quiet ? 0 : $urandom_range(0, 11);
      end else if (!m_tready_i && hold > 0) begin
        hold--;
      end
      m_tready_i <= (hold == 0);
    end
  end

  initial begin
    sb = new();
    quiet = 1'b0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_tvalid_i = 1'b0;
    s_tdata_i = '0;
    num_dims_r = 3'd1;
    select_dim_r = 2'd0;
    sizes_r = 64'h0001_0001_0001_0001;
    src_str_lo_r = '0;
    src_str_hi_r = '0;
    dst_str_lo_r = '0;
    dst_str_hi_r = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: every offset is zero.
    send_request(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    random_burst(20);
    settle();

    // Directed: four dimensions, gather along dimension 1, field extremes.
    write_all(3'd4, 2'd1, 64'h0005_0003_0007_0004, {32'd3, 32'd1},
              {32'd100, 32'd20}, {32'd5, 32'd1}, {32'd70, 32'd10});
    send_request(16'd0, 16'd0, 48'd0);
    send_request(16'hFFFF, 16'd0, 48'd0);
    send_request(16'd0, 16'hFFFF, 48'd0);
    send_request(16'd0, 16'd0, 48'hFFFF_FFFF_FFFF);
    send_request(16'h5555, 16'hAAAA, 48'hAAAA_AAAA_AAAA);
    send_request(16'hAAAA, 16'h5555, 48'h5555_5555_5555);
    send_request(16'd3, 16'd6, 48'd99);
    // Copy number beyond the slice is not checked.
    send_request(16'd1, 16'd2, 48'd100000);
    settle();

    // Overflow: largest sizes and strides.
    write_all(3'd4, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, '1, '1, '1, '1);
    send_request(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    send_request(16'd1, 16'd1, 48'd1);
    send_request(16'd0, 16'd0, 48'd0);
    settle();

    // Zero sizes, zero dimension count, unused register index.
    write_all(3'd0, 2'd2, 64'd0, {32'd9, 32'd2}, {32'd4, 32'd7},
              {32'd1, 32'd3}, {32'd8, 32'd6});
    write_reg(CfgUnused, '1);
    send_request(16'd7, 16'd5, 48'd1234);
    send_request(16'hFFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
    settle();

    // Random configurations, including counts beyond the maximum and
    // selected dimensions outside the used range.
    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph % 4 == 3);
      write_all(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)), rand_sizes(),
                {rand_stride(), rand_stride()}, {rand_stride(), rand_stride()},
                {rand_stride(), rand_stride()}, {rand_stride(), rand_stride()});
      if (ph == 5) write_reg(CfgUnused, {$urandom, $urandom});
      random_burst(125);
      settle();
    end
    quiet = 1'b0;

    repeat (200) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("strided_gather_offset_generator_top_tb: PASS");
    end else begin
      $display("strided_gather_offset_generator_top_tb: FAIL");
    end
    $finish;
  end

endmodule
